// File: sv/jsu_pkg.sv
package jsu_pkg;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // decode modes
    localparam logic [2:0] MODE_NORMAL    = 3'd0;
    localparam logic [2:0] MODE_ESCAPE    = 3'd1;
    localparam logic [2:0] MODE_HEX_FIRST = 3'd2;
    localparam logic [2:0] MODE_HEX_LAST  = 3'd5;

    // byte codes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_FF        = 8'h0C;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_LOW_U     = 8'h75;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] char_value;
        logic [15:0] char_count;
    } out_beat_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // result of one decode step toward the output stage
    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } res_t;

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            h.value = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            h.value = b[3:0] + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: sv/jsu_decode.sv
module jsu_decode
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_beat_t beat,
    output res_t     res
);

    logic [2:0]  mode_reg, mode_next;
    logic [11:0] hex_reg, hex_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] count_inc;
    hex_t        hd;

    assign hd        = hex_digit(beat.in_byte);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;

    always_comb
    begin
        mode_next  = mode_reg;
        hex_next   = hex_reg;
        count_next = count_reg;
        res        = '0;
        if (beat.end_of_input)
        begin
            res.valid     = 1'b1;
            res.beat.kind = KIND_ERROR;
            mode_next     = MODE_NORMAL;
            hex_next      = '0;
            count_next    = '0;
        end
        else if (mode_reg == MODE_ESCAPE)
        begin
            res.valid           = 1'b1;
            res.beat.kind       = KIND_CHAR;
            mode_next           = MODE_NORMAL;
            count_next          = count_inc;
            unique case (beat.in_byte)
                CH_LOW_N:     res.beat.char_value = {8'd0, CH_LF};
                CH_LOW_T:     res.beat.char_value = {8'd0, CH_TAB};
                CH_LOW_R:     res.beat.char_value = {8'd0, CH_CR};
                CH_LOW_B:     res.beat.char_value = {8'd0, CH_BS};
                CH_LOW_F:     res.beat.char_value = {8'd0, CH_FF};
                CH_QUOTE,
                CH_SLASH,
                CH_BACKSLASH: res.beat.char_value = {8'd0, beat.in_byte};
                CH_LOW_U:
                begin
                    res        = '0;
                    mode_next  = MODE_HEX_FIRST;
                    hex_next   = '0;
                    count_next = count_reg;
                end
                default:
                begin
                    res.beat.kind = KIND_ERROR;
                    hex_next      = '0;
                    count_next    = '0;
                end
            endcase
        end
        else if (mode_reg >= MODE_HEX_FIRST && mode_reg <= MODE_HEX_LAST)
        begin
            if (!hd.ok)
            begin
                res.valid     = 1'b1;
                res.beat.kind = KIND_ERROR;
                mode_next     = MODE_NORMAL;
                hex_next      = '0;
                count_next    = '0;
            end
            else if (mode_reg == MODE_HEX_LAST)
            begin
                res.valid           = 1'b1;
                res.beat.kind       = KIND_CHAR;
                res.beat.char_value = {hex_reg, hd.value};
                mode_next           = MODE_NORMAL;
                hex_next            = '0;
                count_next          = count_inc;
            end
            else
            begin
                hex_next  = {hex_reg[7:0], hd.value};
                mode_next = mode_reg + 3'd1;
            end
        end
        else
        begin
            // normal, also unused mode codes
            mode_next = MODE_NORMAL;
            if (beat.in_byte == CH_QUOTE)
            begin
                res.valid           = 1'b1;
                res.beat.kind       = KIND_DONE;
                res.beat.char_count = count_reg;
                hex_next            = '0;
                count_next          = '0;
            end
            else if (beat.in_byte == CH_BACKSLASH)
            begin
                mode_next = MODE_ESCAPE;
            end
            else
            begin
                res.valid           = 1'b1;
                res.beat.kind       = KIND_CHAR;
                res.beat.char_value = {8'd0, beat.in_byte};
                count_next          = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            hex_reg   <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            hex_reg   <= hex_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: sv/jsu_out_stage.sv
module jsu_out_stage
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  res_t      res,
    output logic      free,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    logic      vld_reg, vld_next;
    out_beat_t beat_reg;

    // slot opens when empty or when the held beat leaves this cycle
    assign free     = !vld_reg || !out_stall;
    assign vld_next = load ? res.valid : (vld_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.valid)
        begin
            beat_reg <= res.beat;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = beat_reg;

endmodule

// File: sv/json_string_unescaper_unit.sv
// channel | dir | handshake           | payload
// --------+-----+---------------------+-----------------------------------
// in      | in  | in_valid / in_stall   | in_beat_t: in_byte, end_of_input
// out     | out | out_valid / out_stall | out_beat_t: kind, char_value, char_count
//
// one beat per cycle sustained while out_stall is low; a result reaches out_valid
// after its input beat is taken (input register, then decode logic into the result register)
// bytes that give no result (backslash, \u and its first three hex digits)
// pass the stages without producing an output beat
// rst_n clears the valid bits and the decode state: normal mode, count zero
// out_stall holds the result register and backs up through the input register
// into in_stall in the same cycle, so no beat is dropped
module json_string_unescaper_unit
    import jsu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    logic     in_vld_reg;
    in_beat_t in_beat_reg;
    logic     out_free;
    logic     advance;
    logic     take;
    res_t     res;

    // decode step happens when the input register holds a beat and the
    // result register can take whatever it yields
    assign advance  = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign take     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (take || advance)
        begin
            in_vld_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_beat_reg <= in_data;
        end
    end

    // mode, hex digits and count live here
    jsu_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .beat  (in_beat_reg),
        .res   (res)
    );

    // result register toward the sink
    jsu_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
